FILE: design/aimt_pkg.sv
// Shared widths, codes and types of the action identifier match table.
package aimt_pkg;

  localparam int unsigned TableDepthDef = 64;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned IdentW    = 32;
  localparam int unsigned ParamCntW = 8;
  localparam int unsigned EventW    = 8;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned PinW      = 6;

  localparam int unsigned InDataW   = IdentW + ParamCntW + EventW;
  localparam int unsigned OutFieldW = StatusW + 1 + 1 + PinW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned OutPadW   = OutDataW - OutFieldW;

  // Operation codes
  localparam logic [FuncW-1:0] FuncAdd     = 2'd0;
  localparam logic [FuncW-1:0] FuncRemove  = 2'd1;
  localparam logic [FuncW-1:0] FuncTrigger = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] StsDone     = 3'd0;
  localparam logic [StatusW-1:0] StsBadCount = 3'd1;
  localparam logic [StatusW-1:0] StsFull     = 3'd2;
  localparam logic [StatusW-1:0] StsDup      = 3'd3;
  localparam logic [StatusW-1:0] StsNotFound = 3'd4;

  // Event codes and the one legal parameter count
  localparam logic [EventW-1:0]    EventOff = 8'd0;
  localparam logic [EventW-1:0]    EventOn  = 8'd1;
  localparam logic [ParamCntW-1:0] ParamOne = 8'd1;

  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic [EventW-1:0] code;
  } entry_t;

  typedef struct packed {
    logic scan_pass;
    logic insert_en;
    logic fix_pass;
  } probe_ctrl_t;

  typedef struct packed {
    logic hit;
    logic at_last;
  } probe_stat_t;

endpackage

FILE: design/aimt_cell.sv
// One storage cell of the entry ring: holds an entry and passes it on when shifting.
module aimt_cell import aimt_pkg::*; (
  input  logic   clk_i,
  input  logic   shift_en_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

FILE: design/aimt_probe.sv
// Ring head probe: compares the head entry and picks what re-enters the ring tail.
module aimt_probe import aimt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  probe_ctrl_t ctrl_i,
  input  logic [IdentW-1:0] key_i,
  input  entry_t new_i,
  input  entry_t last_i,
  input  entry_t head_i,
  input  logic [((TableDepth > 1) ? $clog2(TableDepth) : 1)-1:0] idx_i,
  input  logic [$clog2(TableDepth + 1)-1:0] count_i,
  input  logic [((TableDepth > 1) ? $clog2(TableDepth) : 1)-1:0] slot_i,
  output probe_stat_t stat_o,
  output entry_t feed_o
);

  localparam int unsigned CntW = $clog2(TableDepth + 1);

  logic [CntW-1:0] idx_ext;
  logic            in_use;

  assign idx_ext = CntW'(idx_i);
  assign in_use  = idx_ext < count_i;

  assign stat_o.hit     = ctrl_i.scan_pass && in_use && (head_i.ident == key_i);
  assign stat_o.at_last = ctrl_i.scan_pass && in_use && (idx_ext == (count_i - CntW'(1)));

  always_comb begin
    if (ctrl_i.scan_pass && ctrl_i.insert_en && (idx_ext == count_i)) begin
      feed_o = new_i;
    end else if (ctrl_i.fix_pass && (idx_i == slot_i)) begin
      feed_o = last_i;
    end else begin
      feed_o = head_i;
    end
  end

endmodule

FILE: design/action_id_match_table.sv
// Top level of the action identifier match table: ring of entry cells, probe and sequencer.
//
// The table keeps up to TableDepth entries, each an action identifier with an event code,
// in a ring of cells that rotates past a single probe at its head, one position per cycle
// while a request is scanned or fixed up. Every request (add, remove, trigger) rides one
// full rotation; the probe compares each live entry on the way by, appends a new entry at
// the first free position, and notes the last live entry. A remove that finds its
// identifier takes a second rotation that copies the last entry into the freed slot. One
// request is in flight at a time; the result register holds a finished result while the
// master side stalls, and a new request is taken as soon as the sequencer is back in
// idle. The output pin number is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while the block is idle, and the block itself leaves that unchecked.
// Result status: done, bad parameter count, table full, duplicate, not found; a trigger
// that finds event on or off raises drive_strobe with the level (0 on, 1 off) and the
// configured pin, otherwise level and pin read 0.
module action_id_match_table import aimt_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PinW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] ident, [39:32] param_count, [47:40] event_code
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [FuncW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] status, [3] drive_strobe, [4] pin_level, [10:5] drive_pin, rest zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(TableDepth - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(TableDepth);

  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SScan = 5'b00010,
    SEval = 5'b00100,
    SFix  = 5'b01000,
    SDone = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [PinW-1:0]      pin_cfg_q;

  // Request being served
  logic [FuncW-1:0]     func_q;
  logic [IdentW-1:0]    key_q;
  logic [ParamCntW-1:0] pcount_q;
  logic [EventW-1:0]    code_q;

  // Scan findings
  logic                 hit_q;
  logic [IdxW-1:0]      slot_q;
  logic [EventW-1:0]    hit_code_q;
  entry_t               last_q;

  // Finished result and output register
  logic [StatusW-1:0]   status_q;
  logic                 strobe_q;
  logic                 level_q;
  logic [PinW-1:0]      pin_q;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;

  logic                 in_fire;
  logic                 out_load;
  logic                 shift_en;
  probe_ctrl_t          probe_ctrl;
  probe_stat_t          probe_stat;
  entry_t               head;
  entry_t               feed;
  entry_t               new_entry;
  entry_t               ring [TableDepth];

  assign s_axis_tready = (state_q == SIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == SDone) && (!out_valid_q || m_axis_tready);
  assign shift_en      = (state_q == SScan) || (state_q == SFix);

  // ---------------------------------------------------------------------------------------
  // Entry ring: cell k takes from cell k+1, the tail takes what the probe feeds back
  // ---------------------------------------------------------------------------------------
  for (genvar k = 0; k < TableDepth; k++) begin : g_ring
    if (k == TableDepth - 1) begin : g_tail
      aimt_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (shift_en),
        .entry_i    (feed),
        .entry_o    (ring[k])
      );
    end else begin : g_body
      aimt_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (shift_en),
        .entry_i    (ring[k+1]),
        .entry_o    (ring[k])
      );
    end
  end

  assign head            = ring[0];
  assign new_entry.ident = key_q;
  assign new_entry.code  = code_q;

  // Append only for a well-formed add into a table with room and no duplicate seen so far;
  // a duplicate always sits below the append position, so hit_q is settled by then.
  assign probe_ctrl.scan_pass = (state_q == SScan);
  assign probe_ctrl.insert_en = (func_q == FuncAdd) && (pcount_q == ParamOne) &&
                                (count_q < CntFull) && !hit_q;
  assign probe_ctrl.fix_pass  = (state_q == SFix);

  aimt_probe #(
    .TableDepth (TableDepth)
  ) u_probe (
    .ctrl_i  (probe_ctrl),
    .key_i   (key_q),
    .new_i   (new_entry),
    .last_i  (last_q),
    .head_i  (head),
    .idx_i   (idx_q),
    .count_i (count_q),
    .slot_i  (slot_q),
    .stat_o  (probe_stat),
    .feed_o  (feed)
  );

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (idx_q == IdxLast) begin
          idx_d   = '0;
          state_d = SEval;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      SEval: begin
        state_d = SDone;
        if (func_q == FuncAdd) begin
          if (probe_ctrl.insert_en) begin
            count_d = count_q + CntW'(1);
          end
        end else if (func_q == FuncRemove && hit_q) begin
          count_d = count_q - CntW'(1);
          state_d = SFix;
        end
      end
      SFix: begin
        if (idx_q == IdxLast) begin
          idx_d   = '0;
          state_d = SDone;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      SDone: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      idx_q       <= '0;
      count_q     <= '0;
      pin_cfg_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        pin_cfg_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Request capture, scan findings and result
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= s_axis_tuser;
      key_q    <= s_axis_tdata[IdentW-1:0];
      pcount_q <= s_axis_tdata[IdentW +: ParamCntW];
      code_q   <= s_axis_tdata[IdentW + ParamCntW +: EventW];
      hit_q    <= 1'b0;
    end else if (probe_stat.hit) begin
      hit_q      <= 1'b1;
      slot_q     <= idx_q;
      hit_code_q <= head.code;
    end
    if (probe_stat.at_last) begin
      last_q <= head;
    end

    if (state_q == SEval) begin
      status_q <= StsDone;
      strobe_q <= 1'b0;
      level_q  <= 1'b0;
      pin_q    <= '0;
      case (func_q)
        FuncAdd: begin
          if (pcount_q != ParamOne) begin
            status_q <= StsBadCount;
          end else if (count_q >= CntFull) begin
            status_q <= StsFull;
          end else if (hit_q) begin
            status_q <= StsDup;
          end
        end
        FuncRemove: begin
          if (!hit_q) begin
            status_q <= StsNotFound;
          end
        end
        FuncTrigger: begin
          if (!hit_q) begin
            status_q <= StsNotFound;
          end else if (hit_code_q == EventOn) begin
            strobe_q <= 1'b1;
            pin_q    <= pin_cfg_q;
          end else if (hit_code_q == EventOff) begin
            strobe_q <= 1'b1;
            level_q  <= 1'b1;
            pin_q    <= pin_cfg_q;
          end
        end
        default: begin
          status_q <= StsDone;
        end
      endcase
    end

    if (out_load) begin
      out_data_q <= {{OutPadW{1'b0}}, pin_q, level_q, strobe_q, status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count above table depth");

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> (idx_q == '0))
    else $error("ring position not at origin while idle");

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == SScan))
    else $error("accepted request did not start a scan");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SEval) && (func_q == FuncRemove) && hit_q) |=>
      ((count_q == $past(count_q) - CntW'(1)) && (state_q == SFix)))
    else $error("remove hit did not shrink the table");

  a_strobe_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[StatusW]) |-> (out_data_q[StatusW-1:0] == StsDone))
    else $error("drive strobe with a failing status");

endmodule
